// ===== hw/rtl/sqam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqam_pkg
// Shared types, widths and constants for the square QAM symbol modulator.
// ----------------------------------------------------------------------------
package sqam_pkg;

  // Default sizing of the carrier table and the per-symbol sample limit
  localparam int SQAM_SAMPLES_PER_CYCLE      = 16;
  localparam int SQAM_MAX_SAMPLES_PER_SYMBOL = 64;

  // Field widths
  localparam int SYMBOL_W  = 8;
  localparam int SAMPLE_W  = 22;
  localparam int BPA_W     = 3;
  localparam int SPS_W     = 7;
  localparam int STEP_W    = 16;
  localparam int LEVEL_W   = 5;   // signed level, -15 .. 15
  localparam int TRIG_W    = 16;  // Q1.15 carrier value
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [BPA_W-1:0]  BPA_RESET  = 3'd2;
  localparam logic [SPS_W-1:0]  SPS_RESET  = 7'd16;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd256;

  // Axis width limits
  localparam logic [BPA_W-1:0] BPA_MIN = 3'd1;
  localparam logic [BPA_W-1:0] BPA_MAX = 3'd4;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BITS_PER_AXIS      = 2'd0,
    CFG_SAMPLES_PER_SYMBOL = 2'd1,
    CFG_AMPLITUDE_STEP     = 2'd2
  } sqam_cfg_idx_t;

  // Control that travels with each sample through the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } sqam_ctl_t;

endpackage

// ===== hw/rtl/square_qam_symbol_modulator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_qam_symbol_modulator_unit
// Gray-mapped square QAM modulator: one symbol in, its carrier samples out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_symbol) takes one symbol item.
//   Output channel (out_valid / out_stall / out_sample / out_last_sample)
//   gives samples_per_symbol items per symbol, out_last_sample marking the
//   final one. Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   is always ready; write it only while no symbol is in flight.
// Path: after the edge that accepts a symbol, its first sample passes in turn
//   through the sequencer, table lookup, products, scaling and saturation
//   register.
// Throughput: one sample per cycle while out_stall is low; the sequencer
//   issues samples_per_symbol samples (1 .. MAX_SAMPLES_PER_SYMBOL, 16 by
//   default) per symbol, and the next symbol is taken in the cycle its
//   predecessor's last sample is issued.
// Reset: rst_n low clears the pipeline valid bits and returns the registers
//   to bits_per_axis 2, samples_per_symbol 16, amplitude_step 256.
// Stall: out_stall high on a valid output freezes every stage; nothing is
//   dropped or repeated, and in_stall rises while a symbol is being issued.
// ----------------------------------------------------------------------------
module square_qam_symbol_modulator_unit #(
  parameter int SAMPLES_PER_CYCLE      = sqam_pkg::SQAM_SAMPLES_PER_CYCLE,
  parameter int MAX_SAMPLES_PER_SYMBOL = sqam_pkg::SQAM_MAX_SAMPLES_PER_SYMBOL
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sqam_pkg::SYMBOL_W-1:0]         in_symbol,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sqam_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                  out_last_sample,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sqam_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sqam_pkg::STEP_W-1:0]           cfg_data
);

  localparam int PH_W = $clog2(SAMPLES_PER_CYCLE);

  logic                                 adv;
  sqam_pkg::sqam_ctl_t                  seq_ctl, car_ctl, out_ctl;
  logic [PH_W-1:0]                      seq_phase;
  logic signed [sqam_pkg::LEVEL_W-1:0]  seq_li, seq_lq, car_li, car_lq;
  logic [sqam_pkg::STEP_W-1:0]          seq_step, car_step;
  logic signed [sqam_pkg::TRIG_W-1:0]   car_cos, car_sin;
  logic signed [sqam_pkg::SAMPLE_W-1:0] out_data;

  // Whole pipeline moves unless the output register is held
  assign adv       = !(out_ctl.valid && out_stall);
  assign cfg_ready = 1'b1;

  sqam_seq #(
    .SAMPLES_PER_CYCLE      (SAMPLES_PER_CYCLE),
    .MAX_SAMPLES_PER_SYMBOL (MAX_SAMPLES_PER_SYMBOL)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_symbol (in_symbol),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (adv),
    .seq_ctl   (seq_ctl),
    .seq_phase (seq_phase),
    .seq_li    (seq_li),
    .seq_lq    (seq_lq),
    .seq_step  (seq_step)
  );

  sqam_carrier #(
    .SAMPLES_PER_CYCLE (SAMPLES_PER_CYCLE)
  ) u_carrier (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .seq_ctl   (seq_ctl),
    .seq_phase (seq_phase),
    .seq_li    (seq_li),
    .seq_lq    (seq_lq),
    .seq_step  (seq_step),
    .car_ctl   (car_ctl),
    .car_cos   (car_cos),
    .car_sin   (car_sin),
    .car_li    (car_li),
    .car_lq    (car_lq),
    .car_step  (car_step)
  );

  sqam_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .car_ctl  (car_ctl),
    .car_cos  (car_cos),
    .car_sin  (car_sin),
    .car_li   (car_li),
    .car_lq   (car_lq),
    .car_step (car_step),
    .out_ctl  (out_ctl),
    .out_data (out_data)
  );

  assign out_valid       = out_ctl.valid;
  assign out_last_sample = out_ctl.last;
  assign out_sample      = out_data;

  // No new symbol while the current one still has samples to issue
  a_no_accept_mid_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_ctl.valid && !seq_ctl.last) |-> in_stall)
    else $error("symbol accepted before the previous one was fully issued");

  // An accepted symbol starts issuing on the next cycle
  a_accept_starts_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> seq_ctl.valid)
    else $error("accepted symbol did not start issuing");

  // A held output freezes the lookup stage as well
  a_stall_freezes_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(car_ctl) && $stable(car_cos) && $stable(car_sin)))
    else $error("lookup stage moved while the output was held");

endmodule

// ===== hw/rtl/sqam_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqam_seq
// Configuration registers, symbol decode and per-symbol sample sequencer.
// Issues one sample descriptor per advancing cycle.
// ----------------------------------------------------------------------------
module sqam_seq #(
  parameter int SAMPLES_PER_CYCLE      = sqam_pkg::SQAM_SAMPLES_PER_CYCLE,
  parameter int MAX_SAMPLES_PER_SYMBOL = sqam_pkg::SQAM_MAX_SAMPLES_PER_SYMBOL,
  localparam int PH_W = $clog2(SAMPLES_PER_CYCLE)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sqam_pkg::SYMBOL_W-1:0]         in_symbol,
  input  logic                                  cfg_valid,
  input  logic [sqam_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sqam_pkg::STEP_W-1:0]           cfg_data,
  input  logic                                  adv,
  output sqam_pkg::sqam_ctl_t                   seq_ctl,
  output logic [PH_W-1:0]                       seq_phase,
  output logic signed [sqam_pkg::LEVEL_W-1:0]   seq_li,
  output logic signed [sqam_pkg::LEVEL_W-1:0]   seq_lq,
  output logic [sqam_pkg::STEP_W-1:0]           seq_step
);

  localparam int CNT_W = $clog2(MAX_SAMPLES_PER_SYMBOL + 1);
  localparam int CMP_W = (CNT_W > sqam_pkg::SPS_W) ? CNT_W : sqam_pkg::SPS_W;
  localparam logic [CMP_W-1:0] N_MAX = CMP_W'(MAX_SAMPLES_PER_SYMBOL);
  localparam logic [PH_W-1:0]  PH_LAST = PH_W'(SAMPLES_PER_CYCLE - 1);

  logic [sqam_pkg::BPA_W-1:0]  bpa_r;
  logic [sqam_pkg::SPS_W-1:0]  sps_r;
  logic [sqam_pkg::STEP_W-1:0] amp_r;

  logic                        busy_r, busy_nxt;
  logic [CNT_W-1:0]            k_r, k_nxt;
  logic [CNT_W-1:0]            last_k_r, last_k_nxt;
  logic [PH_W-1:0]             phase_r, phase_nxt;
  logic signed [sqam_pkg::LEVEL_W-1:0] li_r, lq_r, li_nxt, lq_nxt;
  logic [sqam_pkg::STEP_W-1:0] step_r;

  logic                        issue_last;
  logic                        accept;
  logic [sqam_pkg::BPA_W-1:0]  b_eff;
  logic [CMP_W-1:0]            n_ext, n_eff;
  logic [3:0]                  mask, hi, lo, g_hi, g_lo;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpa_r <= sqam_pkg::BPA_RESET;
      sps_r <= sqam_pkg::SPS_RESET;
      amp_r <= sqam_pkg::STEP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sqam_pkg::CFG_BITS_PER_AXIS:      bpa_r <= cfg_data[sqam_pkg::BPA_W-1:0];
        sqam_pkg::CFG_SAMPLES_PER_SYMBOL: sps_r <= cfg_data[sqam_pkg::SPS_W-1:0];
        sqam_pkg::CFG_AMPLITUDE_STEP:     amp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the registers to their working ranges
  always_comb begin
    if (bpa_r < sqam_pkg::BPA_MIN) begin
      b_eff = sqam_pkg::BPA_MIN;
    end else if (bpa_r > sqam_pkg::BPA_MAX) begin
      b_eff = sqam_pkg::BPA_MAX;
    end else begin
      b_eff = bpa_r;
    end
    n_ext = CMP_W'(sps_r);
    if (n_ext == '0) begin
      n_eff = CMP_W'(1);
    end else if (n_ext > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = n_ext;
    end
  end

  // Split the symbol per axis and undo the Gray code
  always_comb begin
    mask   = 4'((5'd1 << b_eff) - 5'd1);
    lo     = in_symbol[3:0] & mask;
    hi     = 4'(in_symbol >> b_eff) & mask;
    g_hi   = hi ^ (hi >> 1) ^ (hi >> 2) ^ (hi >> 3);
    g_lo   = lo ^ (lo >> 1) ^ (lo >> 2) ^ (lo >> 3);
    li_nxt = $signed({1'b0, mask} - {g_hi, 1'b0});
    lq_nxt = $signed({1'b0, mask} - {g_lo, 1'b0});
  end

  // Handshake: a new item is taken once the last sample of the current one leaves
  assign issue_last = busy_r && (k_r == last_k_r);
  assign in_stall   = busy_r && !(adv && issue_last);
  assign accept     = in_valid && !in_stall;

  // Sample counter and carrier phase
  always_comb begin
    busy_nxt   = busy_r;
    k_nxt      = k_r;
    last_k_nxt = last_k_r;
    phase_nxt  = phase_r;
    if (accept) begin
      busy_nxt   = 1'b1;
      k_nxt      = '0;
      last_k_nxt = CNT_W'(n_eff - CMP_W'(1));
      phase_nxt  = '0;
    end else if (busy_r && adv) begin
      if (issue_last) begin
        busy_nxt = 1'b0;
      end else begin
        k_nxt     = k_r + CNT_W'(1);
        phase_nxt = (phase_r == PH_LAST) ? '0 : phase_r + PH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    last_k_r <= last_k_nxt;
    phase_r  <= phase_nxt;
    if (accept) begin
      li_r   <= li_nxt;
      lq_r   <= lq_nxt;
      step_r <= amp_r;
    end
  end

  assign seq_ctl.valid = busy_r;
  assign seq_ctl.last  = (k_r == last_k_r);
  assign seq_phase     = phase_r;
  assign seq_li        = li_r;
  assign seq_lq        = lq_r;
  assign seq_step      = step_r;

endmodule

// ===== hw/rtl/sqam_carrier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqam_carrier
// Q1.15 cosine/sine table of one carrier period, built at elaboration from a
// truncated Taylor series, and the registered lookup stage.
// ----------------------------------------------------------------------------
module sqam_carrier #(
  parameter int SAMPLES_PER_CYCLE = sqam_pkg::SQAM_SAMPLES_PER_CYCLE,
  localparam int PH_W = $clog2(SAMPLES_PER_CYCLE)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  sqam_pkg::sqam_ctl_t                   seq_ctl,
  input  logic [PH_W-1:0]                       seq_phase,
  input  logic signed [sqam_pkg::LEVEL_W-1:0]   seq_li,
  input  logic signed [sqam_pkg::LEVEL_W-1:0]   seq_lq,
  input  logic [sqam_pkg::STEP_W-1:0]           seq_step,
  output sqam_pkg::sqam_ctl_t                   car_ctl,
  output logic signed [sqam_pkg::TRIG_W-1:0]    car_cos,
  output logic signed [sqam_pkg::TRIG_W-1:0]    car_sin,
  output logic signed [sqam_pkg::LEVEL_W-1:0]   car_li,
  output logic signed [sqam_pkg::LEVEL_W-1:0]   car_lq,
  output logic [sqam_pkg::STEP_W-1:0]           car_step
);

  // Series term divided by (n+1)(n+2)
  function automatic logic [63:0] div_term(logic [63:0] t, int n);
    logic [63:0] q;
    unique case (n)
      0:       q = t / 64'd2;
      1:       q = t / 64'd6;
      2:       q = t / 64'd12;
      3:       q = t / 64'd20;
      4:       q = t / 64'd30;
      5:       q = t / 64'd42;
      6:       q = t / 64'd56;
      7:       q = t / 64'd72;
      8:       q = t / 64'd90;
      9:       q = t / 64'd110;
      10:      q = t / 64'd132;
      11:      q = t / 64'd156;
      12:      q = t / 64'd182;
      13:      q = t / 64'd210;
      14:      q = t / 64'd240;
      15:      q = t / 64'd272;
      16:      q = t / 64'd306;
      17:      q = t / 64'd342;
      18:      q = t / 64'd380;
      19:      q = t / 64'd420;
      default: q = t;
    endcase
    return q;
  endfunction

  // Alternating Taylor sum in Q2.30
  function automatic longint taylor_q30(logic [63:0] x, logic [63:0] start, int n0);
    logic [63:0] term;
    longint      sum;
    int          n;
    term = start;
    sum  = longint'(start);
    n    = n0;
    for (int k = 0; k < 10; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = div_term(term, n);
      n    = n + 2;
      if ((k % 2) == 1) begin
        sum = sum + longint'(term);
      end else begin
        sum = sum - longint'(term);
      end
    end
    return sum;
  endfunction

  // Round Q2.30 to Q1.15, clamp to 0 .. 32767
  function automatic logic [15:0] to_q15(longint v);
    logic [63:0] r;
    r = (v < 0) ? 64'd0 : 64'(v);
    r = (r + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

  // Carrier value at phase p: sine when want_sin, else cosine
  function automatic logic signed [15:0] carrier_val(int p, logic want_sin);
    int          u;
    int          quad;
    int          rem;
    logic [63:0] x;
    logic [15:0] sv, cv;
    logic signed [15:0] c, s;
    u    = 4 * p;
    quad = (u / SAMPLES_PER_CYCLE) % 4;
    rem  = u % SAMPLES_PER_CYCLE;
    x    = (64'(rem) * sqam_pkg::HALF_PI_Q30) / SAMPLES_PER_CYCLE;
    sv   = to_q15(taylor_q30(x, x, 1));
    cv   = to_q15(taylor_q30(x, 64'd1 << 30, 0));
    unique case (quad)
      0:       begin s = $signed(sv);  c = $signed(cv);  end
      1:       begin s = $signed(cv);  c = -$signed(sv); end
      2:       begin s = -$signed(sv); c = -$signed(cv); end
      default: begin s = -$signed(cv); c = $signed(sv);  end
    endcase
    return want_sin ? s : c;
  endfunction

  logic signed [sqam_pkg::TRIG_W-1:0] cos_tbl [SAMPLES_PER_CYCLE];
  logic signed [sqam_pkg::TRIG_W-1:0] sin_tbl [SAMPLES_PER_CYCLE];

  // Constant table, one entry per phase
  for (genvar g = 0; g < SAMPLES_PER_CYCLE; g++) begin : g_tbl
    assign cos_tbl[g] = carrier_val(g, 1'b0);
    assign sin_tbl[g] = carrier_val(g, 1'b1);
  end

  sqam_pkg::sqam_ctl_t                  ctl_r;
  logic signed [sqam_pkg::TRIG_W-1:0]   cos_r, sin_r;
  logic signed [sqam_pkg::LEVEL_W-1:0]  li_r, lq_r;
  logic [sqam_pkg::STEP_W-1:0]          step_r;

  // Lookup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= seq_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_r  <= cos_tbl[seq_phase];
      sin_r  <= sin_tbl[seq_phase];
      li_r   <= seq_li;
      lq_r   <= seq_lq;
      step_r <= seq_step;
    end
  end

  assign car_ctl  = ctl_r;
  assign car_cos  = cos_r;
  assign car_sin  = sin_r;
  assign car_li   = li_r;
  assign car_lq   = lq_r;
  assign car_step = step_r;

endmodule

// ===== hw/rtl/sqam_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqam_datapath
// Level-by-carrier products, amplitude scaling, floor shift by 15 and
// saturation to 22 bits, in three register stages.
// ----------------------------------------------------------------------------
module sqam_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  sqam_pkg::sqam_ctl_t                   car_ctl,
  input  logic signed [sqam_pkg::TRIG_W-1:0]    car_cos,
  input  logic signed [sqam_pkg::TRIG_W-1:0]    car_sin,
  input  logic signed [sqam_pkg::LEVEL_W-1:0]   car_li,
  input  logic signed [sqam_pkg::LEVEL_W-1:0]   car_lq,
  input  logic [sqam_pkg::STEP_W-1:0]           car_step,
  output sqam_pkg::sqam_ctl_t                   out_ctl,
  output logic signed [sqam_pkg::SAMPLE_W-1:0]  out_data
);

  localparam int PP_W   = sqam_pkg::LEVEL_W + sqam_pkg::TRIG_W;   // 21
  localparam int SUM_W  = PP_W + 1;                               // 22
  localparam int PROD_W = SUM_W + sqam_pkg::STEP_W + 1;           // 39
  localparam int Y_W    = PROD_W - 15;                            // 24
  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((1 << (sqam_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [Y_W-1:0] Y_MIN = -Y_W'(1 << (sqam_pkg::SAMPLE_W - 1));

  sqam_pkg::sqam_ctl_t ctl2_r, ctl3_r, ctl4_r;

  logic signed [PP_W-1:0]   pi_r, pq_r, pi_nxt, pq_nxt;
  logic [sqam_pkg::STEP_W-1:0] step2_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [Y_W-1:0]    y;
  logic signed [sqam_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;

  // Stage 2: per-axis products
  assign pi_nxt = PP_W'(car_li) * PP_W'(car_cos);
  assign pq_nxt = PP_W'(car_lq) * PP_W'(car_sin);

  // Stage 3: sum and amplitude scale
  assign sum      = SUM_W'(pi_r) + SUM_W'(pq_r);
  assign prod_nxt = PROD_W'(sum) * PROD_W'($signed({1'b0, step2_r}));

  // Stage 4: arithmetic shift rounds toward minus infinity, then saturate
  assign y = Y_W'(prod_r >>> 15);
  always_comb begin
    if (y > Y_MAX) begin
      sample_nxt = sqam_pkg::SAMPLE_W'(Y_MAX);
    end else if (y < Y_MIN) begin
      sample_nxt = sqam_pkg::SAMPLE_W'(Y_MIN);
    end else begin
      sample_nxt = sqam_pkg::SAMPLE_W'(y);
    end
  end

  // Control valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else if (adv) begin
      ctl2_r <= car_ctl;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      pi_r     <= pi_nxt;
      pq_r     <= pq_nxt;
      step2_r  <= car_step;
      prod_r   <= prod_nxt;
      sample_r <= sample_nxt;
    end
  end

  assign out_ctl  = ctl4_r;
  assign out_data = sample_r;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Gray-mapped square QAM symbol modulator.
// A directed table covers the level extremes, unused symbol bits, clamped
// register values and zero or large steps. Random phases follow, each with
// its own register setting. Every output sample is compared with a bit-true
// model of the mapper, the Q1.15 carrier table and the floor shift.
// ----------------------------------------------------------------------------
module tb;

  localparam int  CLK_HALF      = 5;
  localparam int  RESET_CYCLES  = 8;
  localparam int  SETTLE_CYCLES = 8;
  localparam int  TAIL_CYCLES   = 20;
  localparam int  HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int  RAND_PHASES   = 10;
  localparam int  PHASE_ITEMS   = 30;
  localparam int  PRESSURE_PH   = 2;
  localparam longint SAMPLE_HI  = 64'sd2097151;
  localparam longint SAMPLE_LO  = -64'sd2097152;
  localparam logic [sqam_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

  typedef struct {
    logic signed [sqam_pkg::SAMPLE_W-1:0] sample;
    logic                                 last;
  } carrier_sample_t;

  // One row of the directed part: a register write or a symbol
  typedef struct {
    bit                             is_cfg;
    logic [sqam_pkg::CFG_IDX_W-1:0] idx;
    logic [sqam_pkg::STEP_W-1:0]    data;
    logic [sqam_pkg::SYMBOL_W-1:0]  symbol;
    bit                             typed;     // every sample of the symbol is typed_val
    int                             typed_val;
  } dir_row_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [sqam_pkg::SYMBOL_W-1:0]        in_symbol = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic signed [sqam_pkg::SAMPLE_W-1:0] out_sample;
  logic                                 out_last_sample;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [sqam_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [sqam_pkg::STEP_W-1:0]          cfg_data = '0;

  // Shadow registers of the modulator
  logic [sqam_pkg::BPA_W-1:0]  axis_bits  = sqam_pkg::BPA_RESET;
  logic [sqam_pkg::SPS_W-1:0]  sym_len    = sqam_pkg::SPS_RESET;
  logic [sqam_pkg::STEP_W-1:0] amp_step   = sqam_pkg::STEP_RESET;

  longint cos_q15 [sqam_pkg::SQAM_SAMPLES_PER_CYCLE];
  longint sin_q15 [sqam_pkg::SQAM_SAMPLES_PER_CYCLE];

  carrier_sample_t pending_samples [$];
  dir_row_t        dir_tab [$];

  int  mismatch_count = 0;
  int  samples_checked = 0;
  int  dir_items = 0;
  int  rand_items = 0;
  int  cfg_writes = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_req = 1'b0;

  square_qam_symbol_modulator_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_symbol       (in_symbol),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_last_sample (out_last_sample),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Carrier math
  // --------------------------------------------------------------------------

  // Taylor sum of the start term and ten more terms in Q2.30, truncating at each step
  function automatic longint series_q30(input longint unsigned x,
                                        input longint unsigned start,
                                        input longint unsigned n0);
    longint unsigned term;
    longint unsigned n;
    longint          sum;
    int              k;
    term = start;
    sum  = longint'(start);
    n    = n0;
    for (k = 0; k < 10; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((n + 1) * (n + 2));
      n    = n + 2;
      if (k[0]) sum = sum + longint'(term);
      else      sum = sum - longint'(term);
    end
    return sum;
  endfunction

  // Q2.30 to Q1.15, rounded, clipped to 0 .. 32767
  function automatic longint round_q15(input longint v);
    longint r;
    if (v < 0) v = 0;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return r;
  endfunction

  // One carrier period of cos and sin
  initial begin : carrier_rom
    longint unsigned u, r, x;
    longint          sv, cv;
    quad_t           quad;
    for (int p = 0; p < sqam_pkg::SQAM_SAMPLES_PER_CYCLE; p++) begin
      u    = longint'(4 * p);
      quad = quad_t'((u / sqam_pkg::SQAM_SAMPLES_PER_CYCLE) & 3);
      r    = u % sqam_pkg::SQAM_SAMPLES_PER_CYCLE;
      x    = (r * sqam_pkg::HALF_PI_Q30) / sqam_pkg::SQAM_SAMPLES_PER_CYCLE;
      sv   = round_q15(series_q30(x, x, 1));
      cv   = round_q15(series_q30(x, 64'd1 << 30, 0));
      case (quad)
        QUAD_I: begin
          sin_q15[p] = sv;  cos_q15[p] = cv;
        end
        QUAD_II: begin
          sin_q15[p] = cv;  cos_q15[p] = -sv;
        end
        QUAD_III: begin
          sin_q15[p] = -sv; cos_q15[p] = -cv;
        end
        default: begin
          sin_q15[p] = -cv; cos_q15[p] = sv;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic int eff_axis_bits();
    if (axis_bits < sqam_pkg::BPA_MIN) return int'(sqam_pkg::BPA_MIN);
    if (axis_bits > sqam_pkg::BPA_MAX) return int'(sqam_pkg::BPA_MAX);
    return int'(axis_bits);
  endfunction

  function automatic int eff_sym_len();
    if (sym_len < 1) return 1;
    if (sym_len > sqam_pkg::SQAM_MAX_SAMPLES_PER_SYMBOL)
      return sqam_pkg::SQAM_MAX_SAMPLES_PER_SYMBOL;
    return int'(sym_len);
  endfunction

  function automatic int gray_to_level(input int g);
    return (g ^ (g >> 1) ^ (g >> 2) ^ (g >> 3)) & 15;
  endfunction

  // Append one expected sample to the scoreboard
  task automatic add_expected(input carrier_sample_t e);
    pending_samples.insert(pending_samples.size(), e);
  endtask

  // Expected carrier samples of one symbol under the current registers
  task automatic queue_symbol_samples(input logic [sqam_pkg::SYMBOL_W-1:0] sym);
    int              b, n, mask, hi, lo, li, lq, ph;
    longint          prod, y;
    carrier_sample_t e;
    b    = eff_axis_bits();
    n    = eff_sym_len();
    mask = (1 << b) - 1;
    lo   = int'(sym) & mask;
    hi   = (int'(sym) >> b) & mask;
    li   = mask - 2 * gray_to_level(hi);
    lq   = mask - 2 * gray_to_level(lo);
    for (int k = 0; k < n; k++) begin
      ph   = k % sqam_pkg::SQAM_SAMPLES_PER_CYCLE;
      prod = (longint'(li) * cos_q15[ph] + longint'(lq) * sin_q15[ph])
             * longint'(amp_step);
      y    = prod >>> 15;   // floor division
      if (y > SAMPLE_HI) y = SAMPLE_HI;
      if (y < SAMPLE_LO) y = SAMPLE_LO;
      e.sample = y[sqam_pkg::SAMPLE_W-1:0];
      e.last   = (k == n - 1);
      add_expected(e);
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Compare each accepted sample with the oldest expectation
  always @(posedge clk) begin : sample_check
    carrier_sample_t exp_s;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d with nothing expected", out_sample));
      end else begin
        exp_s = pending_samples.pop_front();
        samples_checked++;
        if (out_sample !== exp_s.sample)
          report_mismatch($sformatf("sample %0d, wanted %0d", out_sample, exp_s.sample));
        if (out_last_sample !== exp_s.last)
          report_mismatch($sformatf("last flag %b, wanted %b", out_last_sample,
                                    exp_s.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rst_n && $urandom_range(0, 99) < rx_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and register port
  // --------------------------------------------------------------------------

  // Offer one symbol; in_valid stays high afterwards for back-to-back items
  task automatic send_symbol(input logic [sqam_pkg::SYMBOL_W-1:0] sym, input bit typed,
                             input int typed_val);
    carrier_sample_t e;
    int              n;
    in_valid  <= 1'b1;
    in_symbol <= sym;
    do @(posedge clk); while (in_stall);
    if (typed) begin
      n = eff_sym_len();
      for (int k = 0; k < n; k++) begin
        e.sample = typed_val[sqam_pkg::SAMPLE_W-1:0];
        e.last   = (k == n - 1);
        add_expected(e);
      end
    end else begin
      queue_symbol_samples(sym);
    end
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Wait for the block to go idle before touching a register
  task automatic drain_samples();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sqam_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sqam_pkg::STEP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sqam_pkg::CFG_BITS_PER_AXIS:      axis_bits = data[sqam_pkg::BPA_W-1:0];
      sqam_pkg::CFG_SAMPLES_PER_SYMBOL: sym_len   = data[sqam_pkg::SPS_W-1:0];
      sqam_pkg::CFG_AMPLITUDE_STEP:     amp_step  = data;
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Directed table rows
  task automatic row_cfg(input logic [sqam_pkg::CFG_IDX_W-1:0] idx,
                         input logic [sqam_pkg::STEP_W-1:0] data);
    dir_row_t row;
    row.is_cfg    = 1'b1;
    row.idx       = idx;
    row.data      = data;
    row.symbol    = '0;
    row.typed     = 1'b0;
    row.typed_val = 0;
    dir_tab.insert(dir_tab.size(), row);
  endtask

  task automatic row_sym(input logic [sqam_pkg::SYMBOL_W-1:0] sym, input bit typed,
                         input int typed_val);
    dir_row_t row;
    row.is_cfg    = 1'b0;
    row.idx       = sqam_pkg::CFG_BITS_PER_AXIS;
    row.data      = '0;
    row.symbol    = sym;
    row.typed     = typed;
    row.typed_val = typed_val;
    dir_tab.insert(dir_tab.size(), row);
  endtask

  // --------------------------------------------------------------------------
  // Run timeout
  // --------------------------------------------------------------------------
  initial begin : watchdog
    #(20_000_000);
    $display("timeout, %0d samples outstanding", pending_samples.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    logic [sqam_pkg::STEP_W-1:0]   data;
    logic [sqam_pkg::SYMBOL_W-1:0] sym;
    int                            sel;
    int                            rnd;

    // Directed table: register rows (index, data), symbol rows (symbol, typed, value)
    // after reset: bits 2, 16 samples, step 256; upper symbol bits unused
    row_sym(8'h00, 0, 0);
    row_sym(8'hFF, 0, 0);
    row_sym(8'h0F, 0, 0);
    row_sym(8'hF0, 0, 0);
    row_sym(8'h06, 0, 0);
    // 16 levels, one sample, step 1.0: sample is LI * 32767
    row_cfg(sqam_pkg::CFG_BITS_PER_AXIS,      16'h0004);
    row_cfg(sqam_pkg::CFG_SAMPLES_PER_SYMBOL, 16'h0001);
    row_cfg(sqam_pkg::CFG_AMPLITUDE_STEP,     16'h8000);
    row_sym(8'h00, 1, 491505);
    row_sym(8'h80, 1, -491505);
    row_sym(8'h0F, 1, 491505);
    row_sym(8'hFF, 0, 0);
    // zero step, longest symbol: all zeros
    row_cfg(sqam_pkg::CFG_AMPLITUDE_STEP,     16'h0000);
    row_cfg(sqam_pkg::CFG_SAMPLES_PER_SYMBOL, 16'h0040);
    row_sym(8'hFF, 1, 0);
    row_sym(8'h37, 1, 0);
    // full step at the outer corners
    row_cfg(sqam_pkg::CFG_AMPLITUDE_STEP,     16'hFFFF);
    row_sym(8'h00, 0, 0);
    row_sym(8'h88, 0, 0);
    // zero bits and zero length clamp to one; upper data bits dropped
    row_cfg(sqam_pkg::CFG_BITS_PER_AXIS,      16'hFFF8);
    row_cfg(sqam_pkg::CFG_SAMPLES_PER_SYMBOL, 16'hFF80);
    row_sym(8'h00, 0, 0);
    row_sym(8'h01, 0, 0);
    row_sym(8'h02, 0, 0);
    row_sym(8'h03, 0, 0);
    row_sym(8'hFE, 0, 0);
    // bits above four clamp to four, length above the limit clamps to it
    row_cfg(sqam_pkg::CFG_BITS_PER_AXIS,      16'h0007);
    row_cfg(sqam_pkg::CFG_SAMPLES_PER_SYMBOL, 16'h007F);
    row_cfg(sqam_pkg::CFG_AMPLITUDE_STEP,     16'h00FF);
    row_sym(8'h5A, 0, 0);
    row_sym(8'hA5, 0, 0);
    // unused index is ignored; length past one carrier period
    row_cfg(CFG_UNUSED_IDX,                   16'hFFFF);
    row_cfg(sqam_pkg::CFG_BITS_PER_AXIS,      16'h0001);
    row_cfg(sqam_pkg::CFG_SAMPLES_PER_SYMBOL, 16'h0011);
    row_cfg(sqam_pkg::CFG_AMPLITUDE_STEP,     16'h0001);
    row_sym(8'h03, 0, 0);
    row_sym(8'h02, 0, 0);

    // Reset
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    tx_idle_pct = 30;
    rx_idle_pct = 8;
    foreach (dir_tab[r]) begin
      if (dir_tab[r].is_cfg) begin
        drain_samples();
        write_reg(dir_tab[r].idx, dir_tab[r].data);
      end else begin
        sender_gap();
        send_symbol(dir_tab[r].symbol, dir_tab[r].typed, dir_tab[r].typed_val);
        dir_items++;
      end
    end

    // Random phases, each under a fresh register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_samples();

      rnd  = $urandom();
      data = rnd[sqam_pkg::STEP_W-1:0];
      rnd  = $urandom_range(0, 7);
      data[sqam_pkg::BPA_W-1:0] = rnd[sqam_pkg::BPA_W-1:0];
      write_reg(sqam_pkg::CFG_BITS_PER_AXIS, data);

      rnd  = $urandom();
      data = rnd[sqam_pkg::STEP_W-1:0];
      sel  = $urandom_range(0, 9);
      case (sel)
        0:       rnd = 0;
        1:       rnd = 64;
        2:       rnd = $urandom_range(65, 127);
        default: rnd = $urandom_range(1, 20);
      endcase
      if (ph == PRESSURE_PH) rnd = 16;
      data[sqam_pkg::SPS_W-1:0] = rnd[sqam_pkg::SPS_W-1:0];
      write_reg(sqam_pkg::CFG_SAMPLES_PER_SYMBOL, data);

      sel = $urandom_range(0, 9);
      rnd = $urandom();
      if (sel == 0)      data = '0;
      else if (sel == 1) data = '1;
      else               data = rnd[sqam_pkg::STEP_W-1:0];
      write_reg(sqam_pkg::CFG_AMPLITUDE_STEP, data);

      if ($urandom_range(0, 3) == 0) begin
        rnd = $urandom();
        write_reg(CFG_UNUSED_IDX, rnd[sqam_pkg::STEP_W-1:0]);
      end

      // idling profile of the phase; the last one runs flat out
      if (ph == RAND_PHASES - 1) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (ph == PRESSURE_PH) begin
        tx_idle_pct = 0;
        rx_idle_pct = 5;
        hold_req    = 1'b1;
      end else begin
        sel = $urandom_range(0, 2);
        tx_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 20 : 50;
        sel = $urandom_range(0, 2);
        rx_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 4 : 12;
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sender_gap();
        rnd = $urandom_range(0, 255);
        sym = rnd[sqam_pkg::SYMBOL_W-1:0];
        send_symbol(sym, 1'b0, 0);
        rand_items++;
      end
    end

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d directed and %0d random symbols, %0d samples checked,",
             dir_items, rand_items, samples_checked);
    $display("  %0d register writes incl. clamped and unused-index values.", cfg_writes);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sqam_pkg.sv
hw/rtl/sqam_seq.sv
hw/rtl/sqam_carrier.sv
hw/rtl/sqam_datapath.sv
hw/rtl/square_qam_symbol_modulator_unit.sv
test/tb.sv
